// File: hw/rtl/mrte_pkg.sv
`default_nettype none

package mrte_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned WordW    = 32;

  localparam logic REQ_EXEC = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  typedef struct packed {
    logic             req_type;
    logic [IdxW-1:0]  src_a;
    logic [IdxW-1:0]  src_b;
    logic [IdxW-1:0]  dest;
    logic [IdxW-1:0]  shift_amount;
    logic [5:0]       funct_code;
    logic [WordW-1:0] load_value;
  } req_t;

  typedef struct packed {
    logic               wr;
    logic               jmp;
    logic [WordW-1:0]   val;
    logic               mul_en;
    logic [2*WordW-1:0] prod;
  } alu_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/mrte_alu.sv
`default_nettype none

module mrte_alu (
  input  wire mrte_pkg::req_t                 req,
  input  wire logic [mrte_pkg::WordW-1:0]     a,
  input  wire logic [mrte_pkg::WordW-1:0]     b,
  input  wire logic [mrte_pkg::WordW-1:0]     hi,
  input  wire logic [mrte_pkg::WordW-1:0]     lo,
  output mrte_pkg::alu_res_t                  res
);

  logic                             ext_a;
  logic                             ext_b;
  logic signed [mrte_pkg::WordW:0]  mul_a;
  logic signed [mrte_pkg::WordW:0]  mul_b;
  logic signed [2*mrte_pkg::WordW+1:0] mul_full;

  // one 33x33 signed multiplier serves both mult and multu
  assign ext_a    = (req.funct_code == mrte_pkg::FN_MULT) ? a[mrte_pkg::WordW-1] : 1'b0;
  assign ext_b    = (req.funct_code == mrte_pkg::FN_MULT) ? b[mrte_pkg::WordW-1] : 1'b0;
  assign mul_a    = $signed({ext_a, a});
  assign mul_b    = $signed({ext_b, b});
  assign mul_full = mul_a * mul_b;

  always_comb begin
    res        = '0;
    res.prod   = mul_full[2*mrte_pkg::WordW-1:0];
    if (req.req_type == mrte_pkg::REQ_LOAD) begin
      res.wr  = 1'b1;
      res.val = req.load_value;
    end else begin
      res.wr = 1'b1;
      unique case (req.funct_code) inside
        mrte_pkg::FN_ADD, mrte_pkg::FN_ADDU: res.val = a + b;
        mrte_pkg::FN_SUB:  res.val = a - b;
        mrte_pkg::FN_AND:  res.val = a & b;
        mrte_pkg::FN_OR:   res.val = a | b;
        mrte_pkg::FN_XOR:  res.val = a ^ b;
        mrte_pkg::FN_NOR:  res.val = ~(a | b);
        mrte_pkg::FN_NAND: res.val = ~(a & b);
        mrte_pkg::FN_SLT:  res.val = {{(mrte_pkg::WordW-1){1'b0}}, ($signed(a) < $signed(b))};
        mrte_pkg::FN_SLL: begin
          // all-zero sll is the canonical nop
          if (req.src_b == '0 && req.dest == '0 && req.shift_amount == '0) begin
            res.wr = 1'b0;
          end else begin
            res.val = b << req.shift_amount;
          end
        end
        mrte_pkg::FN_SRL:  res.val = b >> req.shift_amount;
        mrte_pkg::FN_SRA:  res.val = $unsigned($signed(b) >>> req.shift_amount);
        mrte_pkg::FN_MFHI: res.val = hi;
        mrte_pkg::FN_MFLO: res.val = lo;
        mrte_pkg::FN_JR: begin
          res.wr  = 1'b0;
          res.jmp = 1'b1;
        end
        mrte_pkg::FN_MULT, mrte_pkg::FN_MULTU: begin
          res.wr     = 1'b0;
          res.mul_en = 1'b1;
        end
        default: res.wr = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mips_r_type_execute.sv
`default_nettype none

// Channel  Dir  tdata (low bit up)                                        tuser
// s_axis   in   src_a, src_b, dest, shift_amount, funct_code, load_value  req_type
// m_axis   out  written_index, written_value, pc_value, hi_value, lo_value
//                                                                         reg_written, jumped
//
// One transaction per cycle sustained while the output is not stalled. A request's register
// operands are read from the register file memory at acceptance; the execute stage then runs
// the ALU and the 33x33 multiplier and commits state as the result enters the output register.
// The last committed write is forwarded to the following request.
// Reset clears the per-entry valid bits, HI, LO and PC at once; no clearing pass.
// A stalled output holds the result and the execute stage; s_axis_tready drops only then.

module mips_r_type_execute (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,  // src_a, src_b, dest, shift_amount, funct_code,
                                           // load_value, zero pad
  input  wire logic [0:0]   s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [135:0]      m_axis_tdata,  // written_index, written_value, pc_value,
                                           // hi_value, lo_value, zero pad
  output logic [1:0]        m_axis_tuser   // reg_written, jumped
);

  localparam int unsigned IW = mrte_pkg::IdxW;
  localparam int unsigned WW = mrte_pkg::WordW;

  mrte_pkg::req_t     in_req;
  mrte_pkg::req_t     ex_req;
  mrte_pkg::alu_res_t alu_res;

  logic [WW-1:0] regs [mrte_pkg::RegCount];
  logic [mrte_pkg::RegCount-1:0] reg_ok;

  logic          ex_valid;
  logic [WW-1:0] rd_a;
  logic [WW-1:0] rd_b;
  logic          rd_a_ok;
  logic          rd_b_ok;

  logic          fwd_valid;
  logic [IW-1:0] fwd_idx;
  logic [WW-1:0] fwd_val;

  logic [WW-1:0] hi;
  logic [WW-1:0] lo;
  logic [WW-1:0] pc;
  logic [WW-1:0] hi_next;
  logic [WW-1:0] lo_next;
  logic [WW-1:0] pc_next;

  logic [WW-1:0] op_a;
  logic [WW-1:0] op_b;
  logic [WW-1:0] wval;
  logic          ex_fire;
  logic          in_fire;

  assign in_req.req_type     = s_axis_tuser[0];
  assign in_req.src_a        = s_axis_tdata[4:0];
  assign in_req.src_b        = s_axis_tdata[9:5];
  assign in_req.dest         = s_axis_tdata[14:10];
  assign in_req.shift_amount = s_axis_tdata[19:15];
  assign in_req.funct_code   = s_axis_tdata[25:20];
  assign in_req.load_value   = s_axis_tdata[57:26];

  assign ex_fire       = ex_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !ex_valid || ex_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // operand select: last committed write wins over the memory read
  always_comb begin
    if (fwd_valid && fwd_idx == ex_req.src_a) begin
      op_a = fwd_val;
    end else begin
      op_a = rd_a_ok ? rd_a : '0;
    end
    if (fwd_valid && fwd_idx == ex_req.src_b) begin
      op_b = fwd_val;
    end else begin
      op_b = rd_b_ok ? rd_b : '0;
    end
  end

  mrte_alu u_alu (
    .req (ex_req),
    .a   (op_a),
    .b   (op_b),
    .hi  (hi),
    .lo  (lo),
    .res (alu_res)
  );

  always_comb begin
    wval    = (ex_req.dest == '0) ? '0 : alu_res.val;
    hi_next = alu_res.mul_en ? alu_res.prod[2*WW-1:WW] : hi;
    lo_next = alu_res.mul_en ? alu_res.prod[WW-1:0] : lo;
    pc_next = alu_res.jmp ? op_a : pc;
  end

  // register file memory: registered reads at acceptance, write on commit
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a <= regs[in_req.src_a];
      rd_b <= regs[in_req.src_b];
    end
    if (ex_fire && alu_res.wr && ex_req.dest != '0) begin
      regs[ex_req.dest] <= alu_res.val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_req  <= in_req;
      rd_a_ok <= reg_ok[in_req.src_a];
      rd_b_ok <= reg_ok[in_req.src_b];
    end
    if (ex_fire) begin
      fwd_idx <= ex_req.dest;
      fwd_val <= wval;
      m_axis_tdata <= {3'b000, lo_next, hi_next, pc_next,
                       alu_res.wr ? wval : {WW{1'b0}},
                       alu_res.wr ? ex_req.dest : {IW{1'b0}}};
      m_axis_tuser <= {alu_res.jmp, alu_res.wr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      fwd_valid     <= 1'b0;
      reg_ok        <= '0;
      hi            <= '0;
      lo            <= '0;
      pc            <= '0;
    end else begin
      if (in_fire) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ex_fire) begin
        hi <= hi_next;
        lo <= lo_next;
        pc <= pc_next;
        // forward only a transaction that wrote a register
        fwd_valid <= alu_res.wr;
        if (alu_res.wr && ex_req.dest != '0) begin
          reg_ok[ex_req.dest] <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
